/* rtl/core/json_string_unescape_decoder_assert.svh */
// ============================================================================
// JSON string unescape decoder: assertion macros
// Concurrent assertion helpers. They are empty when SYNTHESIS is defined.
// ============================================================================
`ifndef JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH
`define JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define JSUD_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// If the trigger holds, the consequence must hold in the next cycle.
`define JSUD_ASSERT_NEXT(lbl, clk_sig, rstn_sig, trig, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (trig) |=> (cons)) else $error(msg);

`else

`define JSUD_ASSERT(lbl, clk_sig, rstn_sig, prop, msg)
`define JSUD_ASSERT_NEXT(lbl, clk_sig, rstn_sig, trig, cons, msg)

`endif

`endif

/* rtl/core/jsud_pkg.sv */
// ============================================================================
// JSON string unescape decoder: package
// Phase and result codes, the result word type and character helpers.
// ============================================================================
package jsud_pkg;

    localparam int unsigned CAP_W = 16;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned PHASE_W = 3;

    // Decoder phases.
    localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_BODY   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESC    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_USKIP1 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_USKIP2 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_UHIGH  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ULOW   = 3'd6;

    // Result kinds.
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_CLOSED  = 3'd1;
    localparam logic [2:0] KIND_NOQUOTE = 3'd2;
    localparam logic [2:0] KIND_UNTERM  = 3'd3;
    localparam logic [2:0] KIND_BADESC  = 3'd4;

    // Characters.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    typedef struct packed {
        logic             valid;
        logic [2:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
    } result_t;

    // Value of one hex digit; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

endpackage

/* rtl/core/jsud_apb_regs.sv */
// ============================================================================
// JSON string unescape decoder: configuration registers
// APB slave holding the output capacity register and the limit derived from it.
// ============================================================================
module jsud_apb_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [jsud_pkg::CAP_W-1:0] limit
);

    logic [jsud_pkg::CAP_W-1:0] capacity_reg;
    logic [jsud_pkg::CAP_W-1:0] capacity_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_en)
            capacity_next = pwdata[jsud_pkg::CAP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= jsud_pkg::CAP_RESET;
        else
            capacity_reg <= capacity_next;
    end

    assign prdata = (paddr[2] == 1'b0) ? {16'd0, capacity_reg} : 32'd0;

    // The terminator takes one place, and a capacity of zero behaves as one.
    assign limit = (capacity_reg == '0) ? '0 : capacity_reg - 1'b1;

endmodule

/* rtl/core/jsud_step.sv */
// ============================================================================
// JSON string unescape decoder: byte step
// Next phase, hex nibble, count and optional result for one source byte.
// ============================================================================
module jsud_step #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic [7:0]                     text_byte,
    input  logic [jsud_pkg::PHASE_W-1:0]   phase,
    input  logic [3:0]                     nibble,
    input  logic [LENGTH_BITS-1:0]         count,
    input  logic [jsud_pkg::CAP_W-1:0]     limit,
    output logic [jsud_pkg::PHASE_W-1:0]   phase_next,
    output logic [3:0]                     nibble_next,
    output logic [LENGTH_BITS-1:0]         count_next,
    output jsud_pkg::result_t              res
);

    localparam int unsigned EXT_W =
        (LENGTH_BITS > jsud_pkg::LEN_W) ? LENGTH_BITS : jsud_pkg::LEN_W;

    logic [LENGTH_BITS-1:0] count_inc;
    logic [EXT_W-1:0]       count_ext;
    logic [EXT_W-1:0]       inc_ext;
    logic [EXT_W-1:0]       limit_ext;
    logic                   full;
    logic                   emit_req;
    logic [7:0]             emit_byte;

    assign count_inc = count + 1'b1;
    assign count_ext = EXT_W'(count);
    assign inc_ext   = EXT_W'(count_inc);
    assign limit_ext = EXT_W'(limit);
    // The count itself also caps the limit when it is all ones.
    assign full      = (count_ext >= limit_ext) || (&count);

    always_comb
    begin
        phase_next  = phase;
        nibble_next = nibble;
        count_next  = count;
        res         = '0;
        emit_req    = 1'b0;
        emit_byte   = text_byte;

        if (phase == jsud_pkg::PH_WAIT)
        begin
            if (text_byte == jsud_pkg::CH_QUOTE)
            begin
                phase_next = jsud_pkg::PH_BODY;
                count_next = '0;
            end
            else
            begin
                res.valid = 1'b1;
                res.kind  = jsud_pkg::KIND_NOQUOTE;
            end
        end
        else if (text_byte == jsud_pkg::CH_NUL)
        begin
            phase_next  = jsud_pkg::PH_WAIT;
            count_next  = '0;
            nibble_next = '0;
            res.valid   = 1'b1;
            res.kind    = jsud_pkg::KIND_UNTERM;
            res.length  = count_ext[jsud_pkg::LEN_W-1:0];
        end
        else
        begin
            case (phase)
                jsud_pkg::PH_BODY:
                begin
                    if (text_byte == jsud_pkg::CH_QUOTE)
                    begin
                        phase_next  = jsud_pkg::PH_WAIT;
                        count_next  = '0;
                        nibble_next = '0;
                        res.valid   = 1'b1;
                        res.kind    = jsud_pkg::KIND_CLOSED;
                        res.length  = count_ext[jsud_pkg::LEN_W-1:0];
                    end
                    else if (text_byte == jsud_pkg::CH_BSLASH)
                        phase_next = jsud_pkg::PH_ESC;
                    else
                        emit_req = 1'b1;
                end
                jsud_pkg::PH_ESC:
                begin
                    case (text_byte)
                        jsud_pkg::CH_QUOTE,
                        jsud_pkg::CH_BSLASH,
                        jsud_pkg::CH_SLASH: emit_req = 1'b1;
                        jsud_pkg::CH_B:
                        begin
                            emit_req  = 1'b1;
                            emit_byte = jsud_pkg::CH_BS;
                        end
                        jsud_pkg::CH_F:
                        begin
                            emit_req  = 1'b1;
                            emit_byte = jsud_pkg::CH_FF;
                        end
                        jsud_pkg::CH_N:
                        begin
                            emit_req  = 1'b1;
                            emit_byte = jsud_pkg::CH_LF;
                        end
                        jsud_pkg::CH_R:
                        begin
                            emit_req  = 1'b1;
                            emit_byte = jsud_pkg::CH_CR;
                        end
                        jsud_pkg::CH_T:
                        begin
                            emit_req  = 1'b1;
                            emit_byte = jsud_pkg::CH_TAB;
                        end
                        jsud_pkg::CH_U: phase_next = jsud_pkg::PH_USKIP1;
                        default:
                        begin
                            phase_next = jsud_pkg::PH_BODY;
                            res.valid  = 1'b1;
                            res.kind   = jsud_pkg::KIND_BADESC;
                            res.length = count_ext[jsud_pkg::LEN_W-1:0];
                        end
                    endcase
                end
                jsud_pkg::PH_USKIP1: phase_next = jsud_pkg::PH_USKIP2;
                jsud_pkg::PH_USKIP2: phase_next = jsud_pkg::PH_UHIGH;
                jsud_pkg::PH_UHIGH:
                begin
                    nibble_next = jsud_pkg::hex_value(text_byte);
                    phase_next  = jsud_pkg::PH_ULOW;
                end
                jsud_pkg::PH_ULOW:
                begin
                    emit_req  = 1'b1;
                    emit_byte = {nibble, jsud_pkg::hex_value(text_byte)};
                end
                default:
                begin
                    phase_next = jsud_pkg::PH_WAIT;
                    count_next = '0;
                end
            endcase
        end

        // Past the limit a decoded byte is dropped without a result.
        if (emit_req)
        begin
            phase_next = jsud_pkg::PH_BODY;
            if (!full)
            begin
                count_next = count_inc;
                res.valid  = 1'b1;
                res.kind   = jsud_pkg::KIND_BYTE;
                res.data   = emit_byte;
                res.length = inc_ext[jsud_pkg::LEN_W-1:0];
            end
        end
    end

endmodule

/* rtl/core/json_string_unescape_decoder.sv */
// ============================================================================
// JSON string unescape decoder: top level
// Decodes a quoted JSON string arriving one source byte per word.
// ============================================================================
// Source bytes enter on the s_axis channel, one byte per word. Results leave
// on the m_axis channel: a decoded byte with the running length, or a status
// word (string closed with its length, missing opening quote, unterminated
// string, bad escape). Bytes that open a string or form part of an escape,
// and bytes beyond the output limit, give no result word.
// The APB port holds output_capacity at address 0; write it only while the
// decoder is idle.
// Each byte is captured in an input register, decoded by one pass of shallow
// logic and, where it gives a result, placed in the output register, from
// which it is shown on m_axis. One byte per cycle is sustained while the
// receiver takes each result. A held result stops the input register, so while
// the receiver stalls only one more byte is taken, into an empty input
// register; when both registers are full, s_axis_tready drops.
// Reset empties both registers, sets output_capacity to 65535 and returns the
// decoder to waiting for an opening quote.
module json_string_unescape_decoder #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] decoded_byte, [23:8] decoded_length
    output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "json_string_unescape_decoder_assert.svh"

    logic [jsud_pkg::CAP_W-1:0]   limit;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [7:0]                   in_byte_reg;
    logic [7:0]                   in_byte_next;

    logic [jsud_pkg::PHASE_W-1:0] phase_reg;
    logic [jsud_pkg::PHASE_W-1:0] phase_next;
    logic [3:0]                   nibble_reg;
    logic [3:0]                   nibble_next;
    logic [LENGTH_BITS-1:0]       count_reg;
    logic [LENGTH_BITS-1:0]       count_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    jsud_pkg::result_t            out_reg;
    jsud_pkg::result_t            out_next;

    logic [jsud_pkg::PHASE_W-1:0] step_phase;
    logic [3:0]                   step_nibble;
    logic [LENGTH_BITS-1:0]       step_count;
    jsud_pkg::result_t            step_res;

    logic                         out_free;
    logic                         advance;
    logic                         accept;

    jsud_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    jsud_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .text_byte   (in_byte_reg),
        .phase       (phase_reg),
        .nibble      (nibble_reg),
        .count       (count_reg),
        .limit       (limit),
        .phase_next  (step_phase),
        .nibble_next (step_nibble),
        .count_next  (step_count),
        .res         (step_res)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            in_valid_next = 1'b0;
            phase_next    = step_phase;
            nibble_next   = step_nibble;
            count_next    = step_count;
            if (step_res.valid)
            begin
                out_valid_next = 1'b1;
                out_next       = step_res;
            end
        end

        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= jsud_pkg::PH_WAIT;
            nibble_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            nibble_reg    <= nibble_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.length, out_reg.data};
    assign m_axis_tuser  = out_reg.kind;

    // A string that closes or breaks off leaves the decoder waiting with a clear count.
    `JSUD_ASSERT_NEXT(a_end_clears, clk, rst_n,
        advance && step_res.valid &&
        (step_res.kind == jsud_pkg::KIND_CLOSED || step_res.kind == jsud_pkg::KIND_UNTERM),
        phase_reg == jsud_pkg::PH_WAIT && count_reg == '0,
        "decoder not back to waiting after end of string")

    // A decoded byte always carries a length of at least one.
    `JSUD_ASSERT(a_byte_len, clk, rst_n,
        !(out_valid_reg && out_reg.kind == jsud_pkg::KIND_BYTE) || out_reg.length != '0,
        "decoded byte reported with zero length")

    // Status words carry no character.
    `JSUD_ASSERT(a_status_data, clk, rst_n,
        !(out_valid_reg && out_reg.kind != jsud_pkg::KIND_BYTE) || out_reg.data == 8'd0,
        "status word carries a character")

    // The input side only stalls when both registers are full and the output is held.
    `JSUD_ASSERT(a_stall_cause, clk, rst_n,
        s_axis_tready || (in_valid_reg && out_valid_reg && !m_axis_tready),
        "input stalled without a full pipeline")

endmodule
